FILE: hdl/pfc_pkg.sv
package pfc_pkg;

	// Request codes carried in req_type
	localparam logic [2:0] REQ_KEY_BEGIN = 3'd0;
	localparam logic [2:0] REQ_KEY_CHAR  = 3'd1;
	localparam logic [2:0] REQ_SEAL      = 3'd2;
	localparam logic [2:0] REQ_TEXT      = 3'd3;
	localparam logic [2:0] REQ_END       = 3'd4;

	// Letter indexes (A = 0)
	localparam logic [4:0] LTR_I = 5'd8;
	localparam logic [4:0] LTR_J = 5'd9;
	localparam logic [4:0] LTR_X = 5'd23;
	localparam logic [4:0] LTR_LAST = 5'd25;

	localparam int unsigned NUM_LETTERS = 26;
	localparam int unsigned NUM_CELLS   = 25;
	localparam logic [4:0] CELLS_FULL = 5'd25;

	localparam logic [7:0] ASCII_UC_A = 8'h41;
	localparam logic [7:0] ASCII_UC_Z = 8'h5A;
	localparam logic [7:0] ASCII_LC_A = 8'h61;
	localparam logic [7:0] ASCII_LC_Z = 8'h7A;
	localparam logic [7:0] ASCII_CASE = 8'h20;
	localparam logic [6:0] ASCII7_A   = 7'h41;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] char_code;
	} req_t;

	typedef struct packed {
		logic [6:0] out_letter;
		logic       pair_last;
		logic       odd_error;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic seal_step;
		logic calc;
		logic load_first;
		logic load_second;
		logic load_err;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic go_seal;
		logic go_pair;
		logic go_err;
		logic seal_last;
		logic out_free;
	} sts_t;

endpackage

FILE: hdl/pfc_ctrl.sv
module pfc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pfc_pkg::sts_t sts,
	output pfc_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEAL,
		ST_CALC,
		ST_OUT0,
		ST_OUT1,
		ST_ERR
	} state_t;

	state_t state_q;

	always_comb begin
		cmd             = '0;
		cmd.accept      = req_valid && (state_q == ST_IDLE);
		cmd.seal_step   = (state_q == ST_SEAL);
		cmd.calc        = (state_q == ST_CALC);
		cmd.load_first  = (state_q == ST_OUT0) && sts.out_free;
		cmd.load_second = (state_q == ST_OUT1) && sts.out_free;
		cmd.load_err    = (state_q == ST_ERR) && sts.out_free;
	end

	assign req_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						if (sts.go_seal)
							state_q <= ST_SEAL;
						else if (sts.go_pair)
							state_q <= ST_CALC;
						else if (sts.go_err)
							state_q <= ST_ERR;
					end
				end
				ST_SEAL: begin
					if (sts.seal_last)
						state_q <= ST_IDLE;
				end
				ST_CALC: begin
					state_q <= ST_OUT0;
				end
				ST_OUT0: begin
					if (sts.out_free)
						state_q <= ST_OUT1;
				end
				ST_OUT1: begin
					if (sts.out_free)
						state_q <= ST_IDLE;
				end
				ST_ERR: begin
					if (sts.out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> (state_q == ST_IDLE && !req_stall))
		else $error("item taken outside idle");

	a_first_then_second: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_first |=> (state_q == ST_OUT1))
		else $error("second letter of digraph skipped");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_first, cmd.load_second, cmd.load_err}))
		else $error("two loads of the output register at once");

endmodule

FILE: hdl/pfc_dp.sv
module pfc_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  pfc_pkg::req_t req_data,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  pfc_pkg::cmd_t cmd,
	output pfc_pkg::sts_t sts,
	output logic          res_valid,
	input  logic          res_stall,
	output pfc_pkg::res_t res_data
);

	// row of a cell index below 25
	function automatic logic [2:0] row_of(input logic [4:0] p);
		logic [2:0] r;
		if (p >= 5'd20)
			r = 3'd4;
		else if (p >= 5'd15)
			r = 3'd3;
		else if (p >= 5'd10)
			r = 3'd2;
		else if (p >= 5'd5)
			r = 3'd1;
		else
			r = 3'd0;
		return r;
	endfunction

	function automatic logic [2:0] step5(input logic [2:0] x, input logic back);
		logic [2:0] y;
		if (back)
			y = (x == 3'd0) ? 3'd4 : x - 3'd1;
		else
			y = (x == 3'd4) ? 3'd0 : x + 3'd1;
		return y;
	endfunction

	function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
		return 5'(r) * 5'd5 + 5'(c);
	endfunction

	logic [4:0] key_mem [pfc_pkg::NUM_CELLS];
	logic [4:0] pos_mem [pfc_pkg::NUM_LETTERS];

	logic        decrypt_q;
	logic [25:0] used_q;
	logic [4:0]  fill_q;
	logic        pend_q;
	logic [4:0]  pend_ltr_q;
	logic [4:0]  seal_q;
	logic [4:0]  pa_q, pb_q;
	logic [4:0]  ka_q, kb_q;
	logic        res_valid_q;
	pfc_pkg::res_t res_q;

	// input decode
	logic [7:0] uc;
	logic       is_ltr;
	logic [4:0] ltr;
	logic       is_text, is_end;
	logic [4:0] pair_b;

	always_comb begin
		uc = req_data.char_code;
		if (uc >= pfc_pkg::ASCII_LC_A && uc <= pfc_pkg::ASCII_LC_Z)
			uc = uc - pfc_pkg::ASCII_CASE;
		is_ltr = (uc >= pfc_pkg::ASCII_UC_A) && (uc <= pfc_pkg::ASCII_UC_Z);
		ltr = 5'(uc - pfc_pkg::ASCII_UC_A);
		if (ltr == pfc_pkg::LTR_J)
			ltr = pfc_pkg::LTR_I;
	end

	assign is_text = (req_data.req_type == pfc_pkg::REQ_TEXT) && is_ltr;
	assign is_end  = (req_data.req_type == pfc_pkg::REQ_END);

	// partner of the pending letter: X on a doubled letter or an encrypt tail
	assign pair_b = (is_end || (!decrypt_q && pend_ltr_q == ltr)) ? pfc_pkg::LTR_X : ltr;

	assign sts.go_seal   = (req_data.req_type == pfc_pkg::REQ_SEAL);
	assign sts.go_pair   = pend_q && (is_text || (is_end && !decrypt_q));
	assign sts.go_err    = pend_q && is_end && decrypt_q;
	assign sts.seal_last = (seal_q == pfc_pkg::LTR_LAST);
	assign sts.out_free  = !res_valid_q || !res_stall;

	// append one letter to the square
	logic       app_en;
	logic [4:0] app_ltr;

	always_comb begin
		app_ltr = cmd.seal_step ? seal_q : ltr;
		app_en  = 1'b0;
		if (cmd.seal_step)
			app_en = 1'b1;
		else if (cmd.accept && req_data.req_type == pfc_pkg::REQ_KEY_CHAR && is_ltr)
			app_en = 1'b1;
		app_en = app_en && !used_q[app_ltr] && (fill_q < pfc_pkg::CELLS_FULL);
	end

	// digraph rule
	logic [4:0] ca_p, cb_p;
	logic [2:0] ra, rb, ca, cb, nra, nrb, nca, ncb;
	logic [4:0] na, nb;

	always_comb begin
		ca_p = (pa_q < pfc_pkg::CELLS_FULL) ? pa_q : 5'd0;
		cb_p = (pb_q < pfc_pkg::CELLS_FULL) ? pb_q : 5'd0;
		ra = row_of(ca_p);
		rb = row_of(cb_p);
		ca = 3'(ca_p - cell_at(ra, 3'd0));
		cb = 3'(cb_p - cell_at(rb, 3'd0));
		nra = step5(ra, decrypt_q);
		nrb = step5(rb, decrypt_q);
		nca = step5(ca, decrypt_q);
		ncb = step5(cb, decrypt_q);
		if (ra == rb) begin
			na = cell_at(ra, nca);
			nb = cell_at(rb, ncb);
		end else if (ca == cb) begin
			na = cell_at(nra, ca);
			nb = cell_at(nrb, cb);
		end else begin
			na = cell_at(ra, cb);
			nb = cell_at(rb, ca);
		end
	end

	always_ff @(posedge clk) begin
		if (app_en) begin
			key_mem[fill_q] <= app_ltr;
			pos_mem[app_ltr] <= fill_q;
		end
		if (cmd.accept) begin
			pa_q <= pos_mem[pend_ltr_q];
			pb_q <= pos_mem[pair_b];
		end
		if (cmd.calc) begin
			ka_q <= key_mem[na];
			kb_q <= key_mem[nb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q   <= 1'b0;
			used_q      <= 26'(1) << pfc_pkg::LTR_J;
			fill_q      <= '0;
			pend_q      <= 1'b0;
			pend_ltr_q  <= '0;
			seal_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				decrypt_q <= cfg_wdata;
			if (app_en) begin
				used_q[app_ltr] <= 1'b1;
				fill_q <= fill_q + 5'd1;
			end
			if (cmd.seal_step)
				seal_q <= seal_q + 5'd1;
			if (cmd.accept) begin
				case (req_data.req_type)
					pfc_pkg::REQ_KEY_BEGIN: begin
						used_q     <= 26'(1) << pfc_pkg::LTR_J;
						fill_q     <= '0;
						pend_q     <= 1'b0;
						pend_ltr_q <= '0;
					end
					pfc_pkg::REQ_SEAL: begin
						seal_q <= '0;
					end
					pfc_pkg::REQ_TEXT: begin
						if (is_ltr) begin
							if (!pend_q) begin
								pend_q     <= 1'b1;
								pend_ltr_q <= ltr;
							end else if (decrypt_q || pend_ltr_q != ltr) begin
								pend_q     <= 1'b0;
								pend_ltr_q <= '0;
							end
						end
					end
					pfc_pkg::REQ_END: begin
						pend_q     <= 1'b0;
						pend_ltr_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.load_first || cmd.load_second || cmd.load_err)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_first) begin
			res_q.out_letter <= pfc_pkg::ASCII7_A + 7'(ka_q);
			res_q.pair_last  <= 1'b0;
			res_q.odd_error  <= 1'b0;
		end else if (cmd.load_second) begin
			res_q.out_letter <= pfc_pkg::ASCII7_A + 7'(kb_q);
			res_q.pair_last  <= 1'b1;
			res_q.odd_error  <= 1'b0;
		end else if (cmd.load_err) begin
			res_q.out_letter <= '0;
			res_q.pair_last  <= 1'b0;
			res_q.odd_error  <= 1'b1;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= pfc_pkg::CELLS_FULL)
		else $error("key square overfilled");

	a_key_begin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && req_data.req_type == pfc_pkg::REQ_KEY_BEGIN)
		|=> (!pend_q && fill_q == 5'd0))
		else $error("key begin left text or fill state behind");

	a_err_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.odd_error) |-> (res_q.out_letter == 7'd0 && !res_q.pair_last))
		else $error("odd tail beat carries a letter");

endmodule

FILE: hdl/playfair_digraph_cipher.sv
// Playfair cipher with an on-chip 5x5 key square.
// Request channel (req_valid / req_stall / req_data): each beat carries a
// request type and a byte. Key begin, key character and unused codes, and text
// or end beats that produce no output, are taken without leaving idle. A seal
// beat walks the 26 letters through the append unit one per cycle, with req_stall high during the walk.
// A text beat that completes a digraph (or an end beat that pads one) fetches
// both letter positions from the position memory as it is taken; a lookup
// state then applies the row, column or rectangle rule and reads the two key
// cells, and two output states load the first and then the second letter,
// each once the output register is free. An odd decrypt tail gives one error
// beat, loaded in an error state after the end beat, and the block takes the
// next request once that beat is in the output register.
// Result channel (res_valid / res_stall / res_data): one letter per beat,
// pair_last set on the second letter of each digraph. An output register
// holds the beat while res_stall is high; the block keeps req_stall high
// until every letter of the current item has been loaded into that register.
// The user writes decrypt_mode through cfg_we / cfg_wdata only while idle; the block does not enforce this.
// Reset (arst_n low) clears the mode to encrypt, the used-letter marks to
// J only, the fill count and the pending letter; the key square and position
// memories hold nothing useful until a key has been sealed.
module playfair_digraph_cipher (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pfc_pkg::req_t req_data,
	output logic          res_valid,
	input  logic          res_stall,
	output pfc_pkg::res_t res_data,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);

	pfc_pkg::cmd_t cmd;
	pfc_pkg::sts_t sts;

	// sequencing: accept, seal walk, lookup, output beats
	pfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// square memories, text pairing and the output register
	pfc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

FILE: verif/playfair_digraph_cipher_tb.sv
`timescale 1ns / 1ps

module playfair_digraph_cipher_tb;

	// Directed key: mixed case, J folded onto I, a repeat, and non-letter bytes,
	// some just outside the letter ranges, that must be dropped.
	localparam logic [7:0] DEMO_KEY [11] = '{
		"P", "l", "a", "y", "j", "I", "z", 8'h00, 8'hFF, "@", "{"
	};
	// Directed plaintext against that key: a doubled letter split by X, a
	// rectangle, a row, a column, a J, and an odd tail padded on end.
	localparam logic [7:0] DEMO_TEXT [8] = '{
		"h", "H", "e", "p", "a", "P", "z", "j"
	};
	// request codes the block ignores
	localparam logic [2:0] REQ_SPARE_LO = 3'd5;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	localparam int unsigned TARGET_BEATS = 750;
	localparam int unsigned QUIET_BEATS  = 620;
	localparam int unsigned PRESSURE_AT  = 300;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 40;

	// Mirror of the cipher: key square, letter positions, pending text letter,
	// and the letters still owed on the result channel.
	class cipher_scoreboard;
		logic [4:0]    square [25];
		logic [5:0]    cell_of_letter [26];
		logic [25:0]   used;
		int unsigned   filled;
		bit            pending_valid;
		logic [4:0]    pending_letter;
		bit            decrypt;
		pfc_pkg::res_t letters_due [$];
		int unsigned   faults;

		function new();
			foreach (square[i]) square[i] = '0;
			foreach (cell_of_letter[i]) cell_of_letter[i] = '0;
			used = 26'd1 << pfc_pkg::LTR_J;
			filled = 0;
			pending_valid = 1'b0;
			pending_letter = '0;
			decrypt = 1'b0;
			faults = 0;
		endfunction

		// Letter index 0..25, or -1 for a byte that is not a letter.
		function int letter_of(logic [7:0] code);
			logic [7:0] u;
			u = code;
			if (u >= pfc_pkg::ASCII_LC_A && u <= pfc_pkg::ASCII_LC_Z)
				u = u - pfc_pkg::ASCII_CASE;
			if (u >= pfc_pkg::ASCII_UC_A && u <= pfc_pkg::ASCII_UC_Z)
				return int'(u - pfc_pkg::ASCII_UC_A);
			return -1;
		endfunction

		function void place(logic [4:0] l);
			if (filled >= pfc_pkg::NUM_CELLS) return;
			used[l] = 1'b1;
			square[filled] = l;
			cell_of_letter[l] = 6'(filled);
			filled++;
		endfunction

		function void owe_letter(logic [4:0] l, bit last);
			pfc_pkg::res_t r;
			r.out_letter = pfc_pkg::ASCII7_A + 7'(l);
			r.pair_last = last;
			r.odd_error = 1'b0;
			letters_due = {letters_due, r};
		endfunction

		// Row, column or rectangle rule on one digraph.
		function void substitute(logic [4:0] a, logic [4:0] b);
			int pa, pb, ra, ca, rb, cb, d, na, nb;
			pa = int'(cell_of_letter[a]);
			pb = int'(cell_of_letter[b]);
			if (pa >= pfc_pkg::NUM_CELLS) pa = 0;
			if (pb >= pfc_pkg::NUM_CELLS) pb = 0;
			ra = pa / 5;
			ca = pa % 5;
			rb = pb / 5;
			cb = pb % 5;
			d = decrypt ? 4 : 1;
			if (ra == rb) begin
				na = ra * 5 + (ca + d) % 5;
				nb = rb * 5 + (cb + d) % 5;
			end else if (ca == cb) begin
				na = ((ra + d) % 5) * 5 + ca;
				nb = ((rb + d) % 5) * 5 + cb;
			end else begin
				na = ra * 5 + cb;
				nb = rb * 5 + ca;
			end
			owe_letter(square[na], 1'b0);
			owe_letter(square[nb], 1'b1);
		endfunction

		function void note_request(pfc_pkg::req_t r);
			int            lt;
			logic [4:0]    l;
			pfc_pkg::res_t flag;
			lt = letter_of(r.char_code);
			l = (lt < 0) ? '0 : 5'(lt);
			if (l == pfc_pkg::LTR_J) l = pfc_pkg::LTR_I;
			case (r.req_type)
			pfc_pkg::REQ_KEY_BEGIN: begin
				used = 26'd1 << pfc_pkg::LTR_J;
				filled = 0;
				pending_valid = 1'b0;
				pending_letter = '0;
			end
			pfc_pkg::REQ_KEY_CHAR: begin
				if (lt >= 0 && !used[l]) place(l);
			end
			pfc_pkg::REQ_SEAL: begin
				for (int i = 0; i < pfc_pkg::NUM_LETTERS; i++)
					if (!used[i]) place(5'(i));
				cell_of_letter[pfc_pkg::LTR_J] = cell_of_letter[pfc_pkg::LTR_I];
			end
			pfc_pkg::REQ_TEXT: begin
				if (lt >= 0) begin
					if (!pending_valid) begin
						pending_valid = 1'b1;
						pending_letter = l;
					end else if (!decrypt && pending_letter == l) begin
						// doubled letter: pair with X, keep the second copy pending
						substitute(l, pfc_pkg::LTR_X);
					end else begin
						pending_valid = 1'b0;
						substitute(pending_letter, l);
						pending_letter = '0;
					end
				end
			end
			pfc_pkg::REQ_END: begin
				if (pending_valid) begin
					pending_valid = 1'b0;
					if (decrypt) begin
						flag.out_letter = '0;
						flag.pair_last = 1'b0;
						flag.odd_error = 1'b1;
						letters_due = {letters_due, flag};
					end else begin
						substitute(pending_letter, pfc_pkg::LTR_X);
					end
					pending_letter = '0;
				end
			end
			default: ;
			endcase
		endfunction

		function void check_letter(pfc_pkg::res_t got);
			pfc_pkg::res_t want;
			if (letters_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: result beat with none due: letter %h last %b err %b",
						$time, got.out_letter, got.pair_last, got.odd_error);
				return;
			end
			want = letters_due.pop_front();
			if (got.out_letter !== want.out_letter || got.pair_last !== want.pair_last ||
				got.odd_error !== want.odd_error) begin
				faults++;
				if (faults <= 10)
					$display("%0t: mismatch: expected %h/%b/%b, got %h/%b/%b",
						$time, want.out_letter, want.pair_last, want.odd_error,
						got.out_letter, got.pair_last, got.odd_error);
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	pfc_pkg::req_t req_data;
	logic          res_valid;
	logic          res_stall;
	pfc_pkg::res_t res_data;
	logic          cfg_we;
	logic          cfg_wdata;

	cipher_scoreboard sb;
	bit               gaps_on;
	bit               hold_go;
	int unsigned      useful_beats;

	playfair_digraph_cipher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Offer one request beat, optionally after an idle burst, and hold it until
	// the block takes it. Valid stays high into the next beat when no gap
	// follows, so back-to-back beats see no bubble.
	task automatic send_item(logic [2:0] kind, logic [7:0] code);
		pfc_pkg::req_t r;
		r.req_type = kind;
		r.char_code = code;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(r);
		if (kind == pfc_pkg::REQ_KEY_BEGIN || kind == pfc_pkg::REQ_SEAL ||
			kind == pfc_pkg::REQ_END ||
			((kind == pfc_pkg::REQ_KEY_CHAR || kind == pfc_pkg::REQ_TEXT) &&
			sb.letter_of(code) >= 0))
			useful_beats++;
	endtask

	// Drop valid, drain every owed letter, then let a seal walk finish.
	task automatic settle();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.letters_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mode writes happen only on an idle block.
	task automatic set_mode(bit m);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		sb.decrypt = m;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] letter_char(int unsigned l);
		logic [7:0] c;
		c = pfc_pkg::ASCII_UC_A + 8'(l);
		if ($urandom_range(0, 1)) c = c + pfc_pkg::ASCII_CASE;
		return c;
	endfunction

	function automatic logic [7:0] noise_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (sb.letter_of(c) >= 0);
		return c;
	endfunction

	// New key: short keys mostly, sometimes every letter in shuffled order plus
	// extras so the square fills before the seal. A few keys go unsealed.
	task automatic random_key();
		int unsigned order [26];
		int unsigned j, tmp, n;
		send_item(pfc_pkg::REQ_KEY_BEGIN, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 5) == 0) begin
			foreach (order[i]) order[i] = i;
			for (int i = 25; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
			foreach (order[i]) send_item(pfc_pkg::REQ_KEY_CHAR, letter_char(order[i]));
			repeat ($urandom_range(1, 3))
				send_item(pfc_pkg::REQ_KEY_CHAR, letter_char($urandom_range(0, 25)));
		end else begin
			n = $urandom_range(0, 12);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					send_item(pfc_pkg::REQ_KEY_CHAR, noise_byte());
				else
					send_item(pfc_pkg::REQ_KEY_CHAR, letter_char($urandom_range(0, 25)));
			end
		end
		if ($urandom_range(0, 9) != 0)
			send_item(pfc_pkg::REQ_SEAL, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 7) == 0)
			send_item(pfc_pkg::REQ_SEAL, 8'($urandom_range(0, 255)));
	endtask

	// Text message: random letters with doubled letters and J's mixed in, plus
	// noise bytes, unused codes, stray ends and seals. Usually closed by an end beat.
	task automatic random_message(int unsigned len);
		int unsigned prev, l;
		prev = $urandom_range(0, 25);
		repeat (len) begin
			case ($urandom_range(0, 23))
			0: send_item(pfc_pkg::REQ_TEXT, noise_byte());
			1: send_item(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)),
				8'($urandom_range(0, 255)));
			2: send_item(pfc_pkg::REQ_END, 8'($urandom_range(0, 255)));
			3: send_item(pfc_pkg::REQ_SEAL, 8'($urandom_range(0, 255)));
			4, 5, 6: send_item(pfc_pkg::REQ_TEXT, letter_char(prev));
			7: send_item(pfc_pkg::REQ_TEXT, letter_char(int'(pfc_pkg::LTR_J)));
			default: begin
				l = $urandom_range(0, 25);
				prev = l;
				send_item(pfc_pkg::REQ_TEXT, letter_char(l));
			end
			endcase
		end
		if ($urandom_range(0, 3) != 0)
			send_item(pfc_pkg::REQ_END, 8'($urandom_range(0, 255)));
	endtask

	// Result side: random stall bursts, and one long hold on request so the
	// output register fills and the block pushes back on requests.
	always begin
		@(posedge clk);
		if (hold_go) begin
			hold_go = 1'b0;
			res_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			res_stall <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 9) == 0) begin
			res_stall <= 1'b1;
			repeat ($urandom_range(1, 19)) @(posedge clk);
			res_stall <= 1'b0;
		end
	end

	// Check every accepted result beat against the oldest owed letter.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) sb.check_letter(res_data);
	end

	initial begin
		#12_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		bit held;
		held = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		res_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		gaps_on = 1'b1;
		hold_go = 1'b0;
		useful_beats = 0;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// End with nothing pending, then a lone text letter that key begin drops;
		// no square read can happen before the first seal.
		send_item(pfc_pkg::REQ_END, 8'h00);
		send_item(pfc_pkg::REQ_TEXT, "q");
		send_item(pfc_pkg::REQ_KEY_BEGIN, 8'hFF);
		foreach (DEMO_KEY[i]) send_item(pfc_pkg::REQ_KEY_CHAR, DEMO_KEY[i]);
		send_item(pfc_pkg::REQ_SEAL, 8'h00);
		send_item(REQ_SPARE_HI, 8'hFF);
		foreach (DEMO_TEXT[i]) send_item(pfc_pkg::REQ_TEXT, DEMO_TEXT[i]);
		send_item(pfc_pkg::REQ_END, 8'h00);

		// Leave a letter pending across the mode switch, then pair it in decrypt
		// mode, try a doubled pair raw, and end on an odd tail.
		send_item(pfc_pkg::REQ_TEXT, "K");
		set_mode(1'b1);
		send_item(pfc_pkg::REQ_TEXT, "m");
		send_item(pfc_pkg::REQ_TEXT, "E");
		send_item(pfc_pkg::REQ_TEXT, "E");
		send_item(pfc_pkg::REQ_TEXT, "b");
		send_item(pfc_pkg::REQ_END, 8'hFF);
		set_mode(1'b0);

		while (useful_beats < TARGET_BEATS) begin
			if (useful_beats >= QUIET_BEATS) gaps_on = 1'b0;
			if (gaps_on && $urandom_range(0, 3) == 0) set_mode(1'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) == 0) random_key();
			if (!held && useful_beats >= PRESSURE_AT) begin
				held = 1'b1;
				hold_go = 1'b1;
				random_message(40);
			end else begin
				random_message($urandom_range(0, 30));
			end
		end

		settle();
		if (sb.faults == 0 && sb.letters_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: playfair_digraph_cipher.f
hdl/pfc_pkg.sv
hdl/pfc_ctrl.sv
hdl/pfc_dp.sv
hdl/playfair_digraph_cipher.sv
verif/playfair_digraph_cipher_tb.sv
